// ===== design/rrf_pkg.sv =====
// ---------------------------------------------------------------------------
// rrf_pkg
// shared types and constants of the reply framer
// ---------------------------------------------------------------------------
`default_nettype none
package rrf_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int LVL_W     = $clog2(MAX_DEPTH) + 1;
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int VAL_W     = 63;
	localparam int LEN_W     = 17;
	localparam int CFG_W     = 16;

	localparam logic [CFG_W-1:0] HDR_LEN_RESET = 16'd512;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BULK  = 8'h24;
	localparam logic [7:0] CH_ARRAY = 8'h2A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MALFORMED  = 3'd1,
		ST_TOO_LONG   = 3'd2,
		ST_TOO_DEEP   = 3'd3,
		ST_INCOMPLETE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RT_SIMPLE = 3'd0,
		RT_ERROR  = 3'd1,
		RT_INT    = 3'd2,
		RT_BULK   = 3'd3,
		RT_ARRAY  = 3'd4
	} rtype_t;

	typedef struct packed {
		logic    count;
		logic    start;
		logic    feed;
		logic    load_bulk;
		logic    bulk_dec;
		logic    push;
		logic    pop;
		logic    dec;
		logic    load;
		logic    clear;
		logic    emit;
		status_t emit_status;
	} rrf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_type;
		logic crlf_hit;
		logic rtype_line;
		logic rtype_bulk;
		logic hdr_bad;
		logic hdr_null;
		logic hdr_zero;
		logic level_full;
		logic too_long;
		logic trailer_bad;
		logic bulk_last;
		logic level_zero;
		logic level_one;
		logic top_one;
	} rrf_stat_t;

endpackage
`default_nettype wire

// ===== design/rrf_if.sv =====
// ---------------------------------------------------------------------------
// rrf_in_if / rrf_out_if
// valid/ready channels for stream bytes and framed replies
// ---------------------------------------------------------------------------
`default_nettype none
interface rrf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;
	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface rrf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [62:0] reply_length;
	logic        is_error_reply;
	modport source (output valid, output status, output reply_length,
		output is_error_reply, input ready);
	modport sink (input valid, input status, input reply_length,
		input is_error_reply, output ready);
endinterface
`default_nettype wire

// ===== design/resp_reply_framer_unit.sv =====
// ---------------------------------------------------------------------------
// resp_reply_framer_unit
// frames top-level replies of a reply byte stream
// ---------------------------------------------------------------------------
// Takes one stream byte per item and emits one result per finished reply,
// per error, and per unfinished reply at an end-of-input byte. A byte that
// finishes a value walks the count stack afterwards in the pop state,
// passing through the load state (stack memory read) for every array it
// closes that sits inside another array. No byte is taken while that walk
// runs or while a result waits unaccepted on the output.
`default_nettype none
module resp_reply_framer_unit import rrf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	rrf_in_if.sink                in_item,
	rrf_out_if.source             out_item
);

	// command and status between sequencer and datapath
	rrf_cmd_t  cmd;
	rrf_stat_t stat;
	logic      ready;

	rrf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_item.valid),
		.end_of_input (in_item.end_of_input),
		.in_ready     (ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	rrf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (in_item.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_item.valid),
		.out_ready   (out_item.ready),
		.out_status  (out_item.status),
		.out_length  (out_item.reply_length),
		.out_is_err  (out_item.is_error_reply)
	);

	// input side handshake
	assign in_item.ready = ready;

endmodule
`default_nettype wire

// ===== design/rrf_datapath.sv =====
// ---------------------------------------------------------------------------
// rrf_datapath
// header number, line and bulk counters, count stack and result register
// ---------------------------------------------------------------------------
`default_nettype none
module rrf_datapath import rrf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic [7:0]       data_byte,
	input  wire rrf_cmd_t         cmd,
	output rrf_stat_t             stat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            out_status,
	output logic [VAL_W-1:0]      out_length,
	output logic                  out_is_err
);

	localparam logic [VAL_W-1:0] LIM63 = {VAL_W{1'b1}};

	logic [CFG_W-1:0] max_len_q;
	rtype_t           rtype_q;
	logic [VAL_W-1:0] hv_q;
	logic             f_sign_q, f_digit_q, f_bad_q, f_cr_q;
	logic [LEN_W-1:0] len_q;
	logic [63:0]      bulk_q;
	logic [VAL_W-1:0] stack_mem [MAX_DEPTH];
	logic [VAL_W-1:0] rd_q;
	logic [VAL_W-1:0] top_q;
	logic [LVL_W-1:0] level_q;
	logic [VAL_W-1:0] bytes_q;
	logic             top_err_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [VAL_W-1:0] out_length_q;
	logic             out_is_err_q;

	// next line state
	logic [LEN_W-1:0] len_inc, content;
	logic             new_cr, is_digit;
	logic [VAL_W+3:0] hv_ext, prod;
	logic             n_sign, n_digit, n_bad;
	logic [VAL_W-1:0] n_hv;

	always_comb begin
		len_inc  = (len_q == {LEN_W{1'b1}}) ? len_q : len_q + LEN_W'(1);
		new_cr   = (data_byte == CH_CR);
		content  = len_inc - LEN_W'(new_cr);
		is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		hv_ext   = {4'b0, hv_q};
		prod     = (hv_ext << 3) + (hv_ext << 1) + {{VAL_W{1'b0}}, data_byte[3:0]};
		n_sign   = f_sign_q;
		n_digit  = f_digit_q;
		n_bad    = f_bad_q | f_cr_q;
		n_hv     = hv_q;
		if (!new_cr) begin
			if (data_byte == CH_MINUS && len_inc == LEN_W'(1)) begin
				n_sign = 1'b1;
			end else if (is_digit) begin
				n_digit = 1'b1;
				if (|prod[VAL_W+3:VAL_W]) begin
					n_bad = 1'b1;
					n_hv  = LIM63;
				end else begin
					n_hv = prod[VAL_W-1:0];
				end
			end else begin
				n_bad = 1'b1;
			end
		end
	end

	always_comb begin
		stat.out_free    = !out_valid_q || out_ready;
		stat.is_type     = (data_byte == CH_PLUS) || (data_byte == CH_MINUS) ||
			(data_byte == CH_COLON) || (data_byte == CH_BULK) || (data_byte == CH_ARRAY);
		stat.crlf_hit    = f_cr_q && (data_byte == CH_LF);
		stat.rtype_line  = (rtype_q == RT_SIMPLE) || (rtype_q == RT_ERROR) ||
			(rtype_q == RT_INT);
		stat.rtype_bulk  = (rtype_q == RT_BULK);
		stat.hdr_bad     = f_bad_q || !f_digit_q || (f_sign_q && hv_q > VAL_W'(1));
		stat.hdr_null    = f_sign_q && (hv_q == VAL_W'(1));
		stat.hdr_zero    = (hv_q == '0);
		stat.level_full  = (level_q >= LVL_W'(MAX_DEPTH));
		stat.too_long    = content > {1'b0, max_len_q};
		stat.trailer_bad = (bulk_q == 64'd2 && data_byte != CH_CR) ||
			(bulk_q == 64'd1 && data_byte != CH_LF);
		stat.bulk_last   = (bulk_q == 64'd1);
		stat.level_zero  = (level_q == '0);
		stat.level_one   = (level_q == LVL_W'(1));
		stat.top_one     = (top_q == VAL_W'(1));
	end

	// count stack: top entry lives in top_q, parents in the memory
	always_ff @(posedge clk) begin
		if (cmd.push && level_q != '0)
			stack_mem[IDX_W'(level_q - LVL_W'(1))] <= top_q;
		if (cmd.pop && level_q >= LVL_W'(2))
			rd_q <= stack_mem[IDX_W'(level_q - LVL_W'(2))];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hv_q  <= '0;
			len_q <= '0;
		end else if (cmd.feed) begin
			hv_q  <= n_hv;
			len_q <= len_inc;
		end
		if (cmd.load_bulk)
			bulk_q <= {1'b0, hv_q} + 64'd2;
		else if (cmd.bulk_dec)
			bulk_q <= bulk_q - 64'd1;
		if (cmd.push)
			top_q <= hv_q;
		else if (cmd.dec)
			top_q <= top_q - VAL_W'(1);
		else if (cmd.load)
			top_q <= rd_q;
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_length_q <= (cmd.emit_status == ST_OK) ? bytes_q : '0;
			out_is_err_q <= (cmd.emit_status == ST_OK) ? top_err_q : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= HDR_LEN_RESET;
			rtype_q     <= RT_SIMPLE;
			f_sign_q    <= 1'b0;
			f_digit_q   <= 1'b0;
			f_bad_q     <= 1'b0;
			f_cr_q      <= 1'b0;
			level_q     <= '0;
			bytes_q     <= '0;
			top_err_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				max_len_q <= cfg_wr_data;
			if (cmd.start) begin
				rtype_q   <= rtype_t'((data_byte == CH_MINUS) ? RT_ERROR :
					(data_byte == CH_COLON) ? RT_INT :
					(data_byte == CH_BULK)  ? RT_BULK :
					(data_byte == CH_ARRAY) ? RT_ARRAY : RT_SIMPLE);
				f_sign_q  <= 1'b0;
				f_digit_q <= 1'b0;
				f_bad_q   <= 1'b0;
				f_cr_q    <= 1'b0;
				if (level_q == '0)
					top_err_q <= (data_byte == CH_MINUS);
			end else if (cmd.feed) begin
				f_sign_q  <= n_sign;
				f_digit_q <= n_digit;
				f_bad_q   <= n_bad;
				f_cr_q    <= new_cr;
			end
			if (cmd.clear) begin
				level_q   <= '0;
				bytes_q   <= '0;
				top_err_q <= 1'b0;
			end else begin
				if (cmd.count && bytes_q != LIM63)
					bytes_q <= bytes_q + VAL_W'(1);
				if (cmd.push)
					level_q <= level_q + LVL_W'(1);
				else if (cmd.pop)
					level_q <= level_q - LVL_W'(1);
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_length = out_length_q;
	assign out_is_err = out_is_err_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(MAX_DEPTH)) else $error("stack level past depth");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (level_q < LVL_W'(MAX_DEPTH)) && (hv_q != '0))
		else $error("bad push");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop || cmd.dec) |-> (level_q != '0)) else $error("pop on empty stack");

endmodule
`default_nettype wire

// ===== design/rrf_ctrl.sv =====
// ---------------------------------------------------------------------------
// rrf_ctrl
// parse phase state machine and stack pop sequencer
// ---------------------------------------------------------------------------
`default_nettype none
module rrf_ctrl import rrf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      end_of_input,
	output logic           in_ready,
	input  wire rrf_stat_t stat,
	output rrf_cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_TYPE = 6'b000001,
		S_LINE = 6'b000010,
		S_BULK = 6'b000100,
		S_SKIP = 6'b001000,
		S_POP  = 6'b010000,
		S_LOAD = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   eoi_q, accept;

	assign in_ready = stat.out_free &&
		(state_q == S_TYPE || state_q == S_LINE || state_q == S_BULK || state_q == S_SKIP);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_TYPE: begin
				if (accept) begin
					cmd.count = 1'b1;
					if (!stat.is_type) begin
						cmd.emit = 1'b1; cmd.emit_status = ST_MALFORMED; cmd.clear = 1'b1;
						state_d = end_of_input ? S_TYPE : S_SKIP;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_LINE;
						if (end_of_input) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE; cmd.clear = 1'b1;
							state_d = S_TYPE;
						end
					end
				end
			end
			S_LINE: begin
				if (accept) begin
					cmd.count = 1'b1;
					if (stat.crlf_hit) begin
						if (stat.rtype_line || (!stat.hdr_bad && stat.hdr_null)) begin
							state_d = S_POP;
						end else if (stat.hdr_bad) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_MALFORMED; cmd.clear = 1'b1;
							state_d = end_of_input ? S_TYPE : S_SKIP;
						end else if (stat.rtype_bulk) begin
							cmd.load_bulk = 1'b1;
							state_d = S_BULK;
							if (end_of_input) begin
								cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE;
								cmd.clear = 1'b1; state_d = S_TYPE;
							end
						end else if (stat.hdr_zero) begin
							state_d = S_POP;
						end else if (stat.level_full) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_TOO_DEEP; cmd.clear = 1'b1;
							state_d = end_of_input ? S_TYPE : S_SKIP;
						end else begin
							cmd.push = 1'b1;
							state_d  = S_TYPE;
							if (end_of_input) begin
								cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE;
								cmd.clear = 1'b1;
							end
						end
					end else begin
						cmd.feed = 1'b1;
						if (stat.too_long) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_TOO_LONG; cmd.clear = 1'b1;
							state_d = end_of_input ? S_TYPE : S_SKIP;
						end else if (end_of_input) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE; cmd.clear = 1'b1;
							state_d = S_TYPE;
						end
					end
				end
			end
			S_BULK: begin
				if (accept) begin
					cmd.count = 1'b1;
					if (stat.trailer_bad) begin
						cmd.emit = 1'b1; cmd.emit_status = ST_MALFORMED; cmd.clear = 1'b1;
						state_d = end_of_input ? S_TYPE : S_SKIP;
					end else begin
						cmd.bulk_dec = 1'b1;
						if (stat.bulk_last) begin
							state_d = S_POP;
						end else if (end_of_input) begin
							cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE; cmd.clear = 1'b1;
							state_d = S_TYPE;
						end
					end
				end
			end
			S_SKIP: begin
				if (accept && end_of_input)
					state_d = S_TYPE;
			end
			S_POP: begin
				state_d = S_TYPE;
				if (stat.level_zero) begin
					cmd.emit = 1'b1; cmd.emit_status = ST_OK; cmd.clear = 1'b1;
				end else if (stat.top_one) begin
					cmd.pop = 1'b1;
					if (stat.level_one) begin
						cmd.emit = 1'b1; cmd.emit_status = ST_OK; cmd.clear = 1'b1;
					end else begin
						state_d = S_LOAD;
					end
				end else begin
					cmd.dec = 1'b1;
					if (eoi_q) begin
						cmd.emit = 1'b1; cmd.emit_status = ST_INCOMPLETE; cmd.clear = 1'b1;
					end
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_POP;
			end
			default: state_d = S_TYPE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TYPE;
			eoi_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				eoi_q <= end_of_input;
		end
	end

	a_pop_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP || state_q == S_LOAD) |-> !in_ready)
		else $error("byte taken during pop");
	a_load_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> $past(state_q) == S_POP) else $error("stray load");
	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SKIP) |-> !cmd.emit) else $error("result while skipping");

endmodule
`default_nettype wire

// ===== tb/tb_resp_reply_framer_unit.sv =====
// ---------------------------------------------------------------------------
// tb_resp_reply_framer_unit
// self-checking bench for the reply framer
// ---------------------------------------------------------------------------
// A queue of stream bytes is filled with directed replies and then with
// random well-formed replies (line, integer, bulk, null, nested arrays),
// some of them corrupted, truncated or mixed with noise. A driver feeds the
// bytes with random gaps, a bit-accurate framing predictor computes the
// expected results and a monitor checks every result item against them.
// The header length limit is changed between phases while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module tb_resp_reply_framer_unit;
	import rrf_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} byte_item_t;

	typedef struct packed {
		status_t     status;
		logic [62:0] len;
		logic        is_err;
	} reply_res_t;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LINE,
		PH_BULK,
		PH_SKIP
	} frame_phase_t;

	localparam logic [62:0] LEN_SAT    = {63{1'b1}};
	localparam int          HOLD_LEN   = 400;
	localparam int          SETTLE     = 40;
	localparam int          WDOG_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	rrf_in_if  in_ch ();
	rrf_out_if out_ch ();

	resp_reply_framer_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_ch),
		.out_item    (out_ch)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// stimulus store and expected replies
	byte_item_t pend_bytes[$];
	byte_item_t build[$];
	reply_res_t exp_replies[$];
	int         mismatches = 0;

	// predictor state
	logic [CFG_W-1:0] hdr_limit;
	frame_phase_t     ph;
	rtype_t           rtype;
	logic [62:0]      hval;
	logic             f_sign, f_digit, f_bad, f_cr;
	logic [LEN_W-1:0] llen;
	logic [63:0]      bulk_left;
	logic [62:0]      cstack [MAX_DEPTH];
	logic [LVL_W-1:0] lvl;
	logic [62:0]      rbytes;
	logic             top_err;

	function automatic void clear_frame();
		ph        = PH_TYPE;
		rtype     = RT_SIMPLE;
		hval      = '0;
		{f_sign, f_digit, f_bad, f_cr} = 4'b0;
		llen      = '0;
		bulk_left = '0;
		lvl       = '0;
		rbytes    = '0;
		top_err   = 1'b0;
	endfunction

	// decimal header digits, saturating with the bad flag on overflow
	function automatic void take_digit(input logic [7:0] b);
		logic [62:0] d;
		if (b == CH_MINUS && llen == 1) begin
			f_sign = 1'b1;
		end else if (b >= "0" && b <= "9") begin
			d = 63'(b - "0");
			f_digit = 1'b1;
			if (hval > (LEN_SAT - d) / 10) begin
				f_bad = 1'b1;
				hval  = LEN_SAT;
			end else begin
				hval = hval * 10 + d;
			end
		end else begin
			f_bad = 1'b1;
		end
	endfunction

	// one value finished: walk up the array counts
	function automatic logic close_value();
		logic [IDX_W-1:0] idx;
		while (lvl != 0) begin
			idx = IDX_W'(lvl - 1);
			cstack[idx] = cstack[idx] - 1;
			if (cstack[idx] != 0)
				return 1'b0;
			lvl = lvl - 1;
		end
		return 1'b1;
	endfunction

	task automatic frame_step(input logic [7:0] b, input logic eoi);
		logic             done;
		logic             have_err;
		logic             known;
		logic             bad;
		status_t          err;
		rtype_t           t;
		logic [LEN_W-1:0] content;
		reply_res_t       r;
		done     = 1'b0;
		have_err = 1'b0;
		err      = ST_OK;
		known    = 1'b1;
		t        = RT_SIMPLE;
		if (ph == PH_SKIP) begin
			if (eoi)
				clear_frame();
			return;
		end
		if (rbytes != LEN_SAT)
			rbytes = rbytes + 1;
		case (ph)
			PH_TYPE: begin
				case (b)
					CH_PLUS:  t = RT_SIMPLE;
					CH_MINUS: t = RT_ERROR;
					CH_COLON: t = RT_INT;
					CH_BULK:  t = RT_BULK;
					CH_ARRAY: t = RT_ARRAY;
					default:  known = 1'b0;
				endcase
				if (!known) begin
					have_err = 1'b1;
					err      = ST_MALFORMED;
				end else begin
					if (lvl == 0)
						top_err = (t == RT_ERROR);
					rtype = t;
					hval  = '0;
					{f_sign, f_digit, f_bad, f_cr} = 4'b0;
					llen  = '0;
					ph    = PH_LINE;
				end
			end
			PH_LINE: begin
				if (f_cr && b == CH_LF) begin
					if (rtype == RT_SIMPLE || rtype == RT_ERROR || rtype == RT_INT) begin
						ph   = PH_TYPE;
						done = close_value();
					end else begin
						bad = f_bad || !f_digit || (f_sign && hval > 1);
						if (bad) begin
							have_err = 1'b1;
							err      = ST_MALFORMED;
						end else if (f_sign && hval == 1) begin
							// null bulk or null array
							ph   = PH_TYPE;
							done = close_value();
						end else if (rtype == RT_BULK) begin
							bulk_left = {1'b0, hval} + 64'd2;
							ph        = PH_BULK;
						end else if (hval == 0) begin
							ph   = PH_TYPE;
							done = close_value();
						end else if (lvl >= MAX_DEPTH) begin
							have_err = 1'b1;
							err      = ST_TOO_DEEP;
						end else begin
							cstack[IDX_W'(lvl)] = hval;
							lvl = lvl + 1;
							ph  = PH_TYPE;
						end
					end
				end else begin
					// a cr not followed by lf is plain content
					if (f_cr)
						f_bad = 1'b1;
					if (llen != {LEN_W{1'b1}})
						llen = llen + 1;
					if (b == CH_CR) begin
						f_cr = 1'b1;
					end else begin
						f_cr = 1'b0;
						take_digit(b);
					end
					content = llen - LEN_W'(f_cr);
					if (content > {1'b0, hdr_limit}) begin
						have_err = 1'b1;
						err      = ST_TOO_LONG;
					end
				end
			end
			default: begin
				if ((bulk_left == 2 && b != CH_CR) || (bulk_left == 1 && b != CH_LF)) begin
					have_err = 1'b1;
					err      = ST_MALFORMED;
				end else begin
					bulk_left = bulk_left - 1;
					if (bulk_left == 0) begin
						ph   = PH_TYPE;
						done = close_value();
					end
				end
			end
		endcase
		if (have_err) begin
			r = '{err, '0, 1'b0};
			exp_replies.push_back(r);
			clear_frame();
			if (!eoi)
				ph = PH_SKIP;
		end else if (done) begin
			r = '{ST_OK, rbytes, top_err};
			exp_replies.push_back(r);
			clear_frame();
		end else if (eoi) begin
			r = '{ST_INCOMPLETE, '0, 1'b0};
			exp_replies.push_back(r);
			clear_frame();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// gap lengths: mostly short, a few long
	logic quiet_in, quiet_out;

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver: one stream byte per accepted item
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid        <= 1'b0;
			in_ch.data_byte    <= '0;
			in_ch.end_of_input <= 1'b0;
			gap_left = 0;
			quiet_in = 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				frame_step(in_ch.data_byte, in_ch.end_of_input);
			if ($urandom_range(0, 199) == 0)
				quiet_in = ~quiet_in;
			if (in_ch.valid && !in_ch.ready) begin
				// hold the offered item
			end else if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pend_bytes.size() > 0) begin
				byte_item_t it;
				it = pend_bytes.pop_front();
				in_ch.data_byte    <= it.b;
				in_ch.end_of_input <= it.eoi;
				in_ch.valid        <= 1'b1;
				gap_left = pick_gap(quiet_in);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in its own process
	logic hold_go;
	logic hold_out;

	initial begin
		hold_out = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_out <= 1'b0;
	end

	// monitor: result items against the oldest expectation
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
			quiet_out  = 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (exp_replies.size() == 0) begin
					report("unexpected result, status", 64'(out_ch.status), 64'hx);
				end else begin
					reply_res_t w;
					w = exp_replies.pop_front();
					if (out_ch.status !== w.status)
						report("status", 64'(out_ch.status), 64'(w.status));
					if (out_ch.reply_length !== w.len)
						report("reply_length", 64'(out_ch.reply_length), 64'(w.len));
					if (out_ch.is_error_reply !== w.is_err)
						report("is_error_reply", 64'(out_ch.is_error_reply), 64'(w.is_err));
				end
			end
			if ($urandom_range(0, 199) == 0)
				quiet_out = ~quiet_out;
			if (hold_out) begin
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap(quiet_out);
			end
		end
	end

	// watchdog on cycles without any accepted item
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_resp_reply_framer_unit NOT OK");
			$finish;
		end
	end

	// stimulus building
	function automatic void put(input string s, input logic eoi_last);
		byte_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.b   = s[i];
			it.eoi = eoi_last && (i == s.len() - 1);
			build.push_back(it);
		end
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		byte_item_t it;
		it.b   = b;
		it.eoi = 1'b0;
		build.push_back(it);
	endfunction

	function automatic void flush_build();
		foreach (build[i])
			pend_bytes.push_back(build[i]);
		build.delete();
	endfunction

	function automatic void put_line_text();
		int n;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				put_byte(8'($urandom_range(0, 255)));
			else
				put_byte(8'($urandom_range("a", "z")));
		end
		put("\r\n", 1'b0);
	endfunction

	function automatic void gen_value(input int depth);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			put("+", 1'b0);
			put_line_text();
		end else if (r < 20) begin
			put("-", 1'b0);
			put_line_text();
		end else if (r < 30) begin
			if ($urandom_range(0, 9) == 0)
				put($sformatf(":%0d\r\n", 64'($urandom) * 64'($urandom)), 1'b0);
			else
				put($sformatf(":%0d\r\n", $urandom_range(0, 100000) - 5), 1'b0);
		end else if (r < 45) begin
			n = $urandom_range(0, 6);
			put($sformatf("$%0d\r\n", n), 1'b0);
			for (int i = 0; i < n; i++)
				put_byte(8'($urandom_range(0, 255)));
			put("\r\n", 1'b0);
		end else if (r < 53) begin
			put(($urandom_range(0, 1) != 0) ? "$-1\r\n" : "*-1\r\n", 1'b0);
		end else if (depth < 5) begin
			n = (depth > 2) ? $urandom_range(0, 1) : $urandom_range(0, 3);
			put($sformatf("*%0d\r\n", n), 1'b0);
			for (int i = 0; i < n; i++)
				gen_value(depth + 1);
		end else begin
			put(":7\r\n", 1'b0);
		end
	endfunction

	// nested single-element arrays; seventeen levels overflow the stack
	function automatic void gen_chain(input int levels);
		for (int i = 0; i < levels; i++)
			put("*1\r\n", 1'b0);
		put("+x\r\n", 1'b0);
	endfunction

	task automatic run_random(input int n_bytes, input logic with_hold);
		int added;
		int r;
		int k;
		added = 0;
		while (added < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					put_byte(8'($urandom_range(0, 255)));
			end else if (r < 10) begin
				gen_chain($urandom_range(14, 17));
			end else begin
				gen_value(0);
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				build[$urandom_range(0, build.size() - 1)].b = 8'($urandom_range(0, 255));
			end else if (r < 14) begin
				k = $urandom_range(0, build.size() - 1);
				build = build[0:k];
				build[k].eoi = 1'b1;
			end
			if ($urandom_range(0, 3) == 0)
				build[build.size() - 1].eoi = 1'b1;
			added += build.size();
			flush_build();
			// let the sender run ahead, then stall the receiver once
			if (with_hold && added > n_bytes / 3)
				hold_go = 1'b1;
			while (pend_bytes.size() > 40)
				@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (pend_bytes.size() != 0 || in_ch.valid || exp_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_hdr_limit(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hdr_limit = v;
	endtask

	initial begin
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		hold_go     = 1'b0;
		hdr_limit   = HDR_LEN_RESET;
		clear_frame();
		foreach (cstack[i])
			cstack[i] = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed replies at the reset header limit
		put("+OK\r\n", 1'b0);
		put("-ERR x\r\n", 1'b0);
		put(":-0\r\n:12\r\n", 1'b0);
		put("$3\r\nabc\r\n$0\r\n\r\n$-1\r\n*-1\r\n*0\r\n", 1'b0);
		put("*2\r\n:1\r\n$1\r\nz\r\n", 1'b0);
		put("+A\rB\r\n", 1'b0);
		put("x!z", 1'b1);                        // bad type byte
		put(":99999999999999999999\r\nz", 1'b1); // number overflow
		put("$-2\r\nz", 1'b1);                   // negative other than null
		put("$\r\nz", 1'b1);                     // empty number
		put("*1-\r\nz", 1'b1);                   // minus past the start
		put("$2\r\nab!!z", 1'b1);                // bad bulk trailer
		gen_chain(17);                           // too deep
		put("z", 1'b1);
		put("$1\r\nx\r\n", 1'b1);                // done on the last byte
		put("+AB", 1'b1);                        // incomplete
		put("$9223372036854775807\r\nab", 1'b1);
		put("x", 1'b1);                          // error on the last byte
		put_byte(8'hFF);
		put_byte(8'h00);
		put("\r\n", 1'b1);
		flush_build();
		wait_idle();

		set_hdr_limit(16'd6);
		put("+abcdef\r\n+abcdefg\r\nz", 1'b1);   // at and past the limit
		flush_build();
		run_random(150, 1'b1);
		wait_idle();

		set_hdr_limit(16'd1);
		run_random(60, 1'b0);
		wait_idle();

		set_hdr_limit(16'hFFFF);
		run_random(90, 1'b0);
		wait_idle();

		set_hdr_limit(HDR_LEN_RESET);
		run_random(130, 1'b0);
		wait_idle();

		if (mismatches == 0)
			$display("tb_resp_reply_framer_unit OK");
		else
			$display("tb_resp_reply_framer_unit NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
